@@ src/ahpp_pkg.sv @@
// ----------------------------------------------------------------------------
// ahpp_pkg
// shared constants for the amide hydrogen pair placement datapath
// ----------------------------------------------------------------------------
package ahpp_pkg;

    // normalising shift applied to |n| and to every division numerator
    localparam int NORM_SHIFT = 14;

    // output scaling: results are formed in units of 2^-31 then rounded
    localparam int ROUND_SHIFT = 31;

    // sqrt(3) in q1.30, rounded
    localparam int SQRT3_W = 31;
    localparam logic [SQRT3_W-1:0] SQRT3_Q30 = 31'd1859775393;

endpackage

@@ src/ahpp_div.sv @@
// ----------------------------------------------------------------------------
// ahpp_div
// pipelined restoring divider, signed numerator scaled by 2^NORM_SHIFT,
// positive divisor, quotient truncated toward zero, one bit per stage
// ----------------------------------------------------------------------------
module ahpp_div #(
    parameter int NUM_W = 68,
    parameter int DEN_W = 47,
    parameter int QUO_W = 35
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num_i,
    input  logic        [DEN_W-1:0] den_i,
    output logic signed [QUO_W:0]   quo_o
);
    import ahpp_pkg::*;

    localparam int MAG_W = NUM_W + NORM_SHIFT;
    localparam int IW    = (MAG_W > DEN_W + QUO_W) ? MAG_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] mag;
    logic [IW-1:0]    rem_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic [IW-1:0]    test    [0:QUO_W-1];
    logic             ge      [0:QUO_W-1];
    logic signed [QUO_W:0] quo_o_reg;

    assign mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

    always_comb begin
        for (int j = 0; j < QUO_W; j++) begin
            test[j] = IW'(den_reg[j]) << (QUO_W - 1 - j);
            ge[j]   = rem_reg[j] >= test[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= IW'(mag) << NORM_SHIFT;
            quo_reg[0] <= '0;
            den_reg[0] <= den_i;
            neg_reg[0] <= num_i[NUM_W-1];
            for (int j = 0; j < QUO_W; j++) begin
                rem_reg[j+1] <= ge[j] ? rem_reg[j] - test[j] : rem_reg[j];
                quo_reg[j+1] <= {quo_reg[j][QUO_W-2:0], ge[j]};
                den_reg[j+1] <= den_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            quo_o_reg <= neg_reg[QUO_W] ? -$signed({1'b0, quo_reg[QUO_W]})
                                        : $signed({1'b0, quo_reg[QUO_W]});
        end
    end

    assign quo_o = quo_o_reg;

endmodule

@@ src/amide_hydrogen_pair_placement.sv @@
// ----------------------------------------------------------------------------
// amide_hydrogen_pair_placement
// places two hydrogens at 120 degree offsets around a nitrogen from its
// bonded carbon and hydrogen, q16.16 coordinates, saturating outputs
// ----------------------------------------------------------------------------
// pipeline depth is set by the bit-per-stage square root and the two
// bit-per-stage division passes
// throughput: one transaction per cycle, the output skid stage stalls the
// pipeline only after two results are held
// reset: synchronous active-low aresetn clears valid bits and the skid stage
module amide_hydrogen_pair_placement #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // nitrogen_x/y/z, carbon_x/y/z, hydrogen_x/y/z, zero padded
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // first_x/y/z, second_x/y/z, zero padded
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // degenerate
    output logic [0:0]                            m_axis_tuser
);
    import ahpp_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int OUT_W = ((6*COORD_WIDTH+7)/8)*8;
    localparam int DW    = W + 1;
    localparam int PW    = 2*W + 2;
    localparam int SW    = 2*W + 4;
    localparam int XW    = PW + 2*NORM_SHIFT;
    localparam int RW    = XW / 2;
    localparam int QW    = W + 3;
    localparam int AW    = QW + 1;
    localparam int AMW   = AW + DW;
    localparam int LD    = QW + 2;
    localparam int XFW   = W + 8;
    localparam int RPW   = AW + SQRT3_W + 1;
    localparam int FW    = W + 40;
    localparam int XS    = ROUND_SHIFT - 1;
    localparam logic signed [FW-1:0] ROUND_HALF = FW'(1) <<< XS;

    // input fields
    logic signed [W-1:0] n_f [3];
    logic signed [W-1:0] c_f [3];
    logic signed [W-1:0] h_f [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_f[k] = s_axis_tdata[k*W +: W];
            c_f[k] = s_axis_tdata[(3+k)*W +: W];
            h_f[k] = s_axis_tdata[(6+k)*W +: W];
        end
    end

    // valid bits
    logic          va_reg, vb_reg, vc_reg, vm_reg, vf_reg;
    logic [RW:0]   vi_reg;
    logic [LD-1:0] vd_reg, ve_reg;

    // stage a: differences
    logic signed [W-1:0]  base_a_reg [3];
    logic signed [DW-1:0] nv_a_reg [3];
    logic signed [DW-1:0] dv_a_reg [3];
    // stage b: products
    logic signed [W-1:0]  base_b_reg [3];
    logic signed [DW-1:0] nv_b_reg [3];
    logic signed [DW-1:0] dv_b_reg [3];
    logic signed [PW-1:0] nn_b_reg [3];
    logic signed [PW-1:0] nd_b_reg [3];
    logic signed [PW-1:0] xp_b_reg [6];
    // stage c: dot and cross sums
    logic signed [W-1:0]  base_c_reg [3];
    logic signed [DW-1:0] nv_c_reg [3];
    logic signed [DW-1:0] dv_c_reg [3];
    logic [PW-1:0]        q_c_reg;
    logic signed [SW-1:0] t_c_reg;
    logic signed [SW-1:0] cr_c_reg [3];
    // square root pipeline
    logic [XW-1:0]        sq_rem_reg  [0:RW];
    logic [RW-1:0]        sq_root_reg [0:RW];
    logic [XW-1:0]        sq_test [0:RW-1];
    logic                 sq_ge   [0:RW-1];
    logic signed [SW-1:0] t_i_reg    [0:RW];
    logic signed [SW-1:0] cr_i_reg   [0:RW][3];
    logic signed [DW-1:0] nv_i_reg   [0:RW][3];
    logic signed [DW-1:0] dv_i_reg   [0:RW][3];
    logic signed [W-1:0]  base_i_reg [0:RW][3];
    logic                 deg_i_reg  [0:RW];
    // projection length division
    logic signed [AW-1:0] a_quo;
    logic [RW-1:0]        lq_d_reg   [0:LD-1];
    logic signed [SW-1:0] cr_d_reg   [0:LD-1][3];
    logic signed [DW-1:0] nv_d_reg   [0:LD-1][3];
    logic signed [DW-1:0] dv_d_reg   [0:LD-1][3];
    logic signed [W-1:0]  base_d_reg [0:LD-1][3];
    logic                 deg_d_reg  [0:LD-1];
    // stage m: a * n
    logic signed [AMW-1:0] am_m_reg [3];
    logic [RW-1:0]         lq_m_reg;
    logic signed [SW-1:0]  cr_m_reg [3];
    logic signed [DW-1:0]  dv_m_reg [3];
    logic signed [W-1:0]   base_m_reg [3];
    logic                  deg_m_reg;
    // component divisions
    logic signed [AW-1:0] p_quo [3];
    logic signed [AW-1:0] r_quo [3];
    logic signed [DW-1:0] dv_e_reg   [0:LD-1][3];
    logic signed [W-1:0]  base_e_reg [0:LD-1][3];
    logic                 deg_e_reg  [0:LD-1];
    // stage f: base sums and sqrt(3) products
    logic signed [XFW-1:0] x_f_reg [3];
    logic signed [RPW-1:0] rp_f_reg [3];
    logic                  deg_f_reg;
    // output and skid
    logic                  out_v_reg, skid_v_reg;
    logic [OUT_W-1:0]      out_data_reg, skid_data_reg, res_data;
    logic                  out_deg_reg, skid_deg_reg;
    logic signed [FW-1:0]  sum_pos [3];
    logic signed [FW-1:0]  sum_neg [3];

    logic en;
    assign en = !skid_v_reg;
    assign s_axis_tready = en;

    function automatic logic [W-1:0] sat_coord(input logic signed [FW-1:0] s);
        logic signed [FW-ROUND_SHIFT-1:0] sh;
        logic [FW-ROUND_SHIFT-W:0]        hi;
        logic [W-1:0]                     res;
        sh = s[FW-1:ROUND_SHIFT];
        hi = sh[FW-ROUND_SHIFT-1:W-1];
        if (&hi || ~|hi) begin
            res = sh[W-1:0];
        end else if (sh[FW-ROUND_SHIFT-1]) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            vc_reg     <= 1'b0;
            vi_reg     <= '0;
            vd_reg     <= '0;
            vm_reg     <= 1'b0;
            ve_reg     <= '0;
            vf_reg     <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (en) begin
                va_reg <= s_axis_tvalid;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                vi_reg <= {vi_reg[RW-1:0], vc_reg};
                vd_reg <= {vd_reg[LD-2:0], vi_reg[RW]};
                vm_reg <= vd_reg[LD-1];
                ve_reg <= {ve_reg[LD-2:0], vm_reg};
                vf_reg <= ve_reg[LD-1];
            end
            if (skid_v_reg) begin
                if (m_axis_tready) begin
                    out_data_reg <= skid_data_reg;
                    out_deg_reg  <= skid_deg_reg;
                    skid_v_reg   <= 1'b0;
                end
            end else if (vf_reg) begin
                if (!out_v_reg || m_axis_tready) begin
                    out_data_reg <= res_data;
                    out_deg_reg  <= deg_f_reg;
                    out_v_reg    <= 1'b1;
                end else begin
                    skid_data_reg <= res_data;
                    skid_deg_reg  <= deg_f_reg;
                    skid_v_reg    <= 1'b1;
                end
            end else if (m_axis_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < RW; j++) begin
            sq_test[j] = (XW'(sq_root_reg[j]) << (2*(RW-1-j)+2)) |
                         (XW'(1) << (2*(RW-1-j)));
            sq_ge[j]   = sq_rem_reg[j] >= sq_test[j];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                base_a_reg[k] <= n_f[k];
                nv_a_reg[k]   <= DW'(c_f[k]) - DW'(n_f[k]);
                dv_a_reg[k]   <= DW'(h_f[k]) - DW'(n_f[k]);
                base_b_reg[k] <= base_a_reg[k];
                nv_b_reg[k]   <= nv_a_reg[k];
                dv_b_reg[k]   <= dv_a_reg[k];
                nn_b_reg[k]   <= PW'(nv_a_reg[k]) * PW'(nv_a_reg[k]);
                nd_b_reg[k]   <= PW'(dv_a_reg[k]) * PW'(nv_a_reg[k]);
                base_c_reg[k] <= base_b_reg[k];
                nv_c_reg[k]   <= nv_b_reg[k];
                dv_c_reg[k]   <= dv_b_reg[k];
            end
            xp_b_reg[0] <= PW'(dv_a_reg[1]) * PW'(nv_a_reg[2]);
            xp_b_reg[1] <= PW'(dv_a_reg[2]) * PW'(nv_a_reg[1]);
            xp_b_reg[2] <= PW'(dv_a_reg[2]) * PW'(nv_a_reg[0]);
            xp_b_reg[3] <= PW'(dv_a_reg[0]) * PW'(nv_a_reg[2]);
            xp_b_reg[4] <= PW'(dv_a_reg[0]) * PW'(nv_a_reg[1]);
            xp_b_reg[5] <= PW'(dv_a_reg[1]) * PW'(nv_a_reg[0]);

            q_c_reg <= PW'(SW'(nn_b_reg[0]) + SW'(nn_b_reg[1]) + SW'(nn_b_reg[2]));
            t_c_reg <= SW'(nd_b_reg[0]) + SW'(nd_b_reg[1]) + SW'(nd_b_reg[2]);
            for (int k = 0; k < 3; k++) begin
                cr_c_reg[k] <= SW'(xp_b_reg[2*k]) - SW'(xp_b_reg[2*k+1]);
            end

            // square root of q scaled by 2^(2*NORM_SHIFT)
            sq_rem_reg[0]  <= XW'(q_c_reg) << (2*NORM_SHIFT);
            sq_root_reg[0] <= '0;
            t_i_reg[0]     <= t_c_reg;
            deg_i_reg[0]   <= (q_c_reg == '0) ||
                              (cr_c_reg[0] == '0 && cr_c_reg[1] == '0 && cr_c_reg[2] == '0);
            for (int k = 0; k < 3; k++) begin
                cr_i_reg[0][k]   <= cr_c_reg[k];
                nv_i_reg[0][k]   <= nv_c_reg[k];
                dv_i_reg[0][k]   <= dv_c_reg[k];
                base_i_reg[0][k] <= base_c_reg[k];
            end
            for (int j = 0; j < RW; j++) begin
                sq_rem_reg[j+1]  <= sq_ge[j] ? sq_rem_reg[j] - sq_test[j] : sq_rem_reg[j];
                sq_root_reg[j+1] <= {sq_root_reg[j][RW-2:0], sq_ge[j]};
                t_i_reg[j+1]     <= t_i_reg[j];
                deg_i_reg[j+1]   <= deg_i_reg[j];
                cr_i_reg[j+1]    <= cr_i_reg[j];
                nv_i_reg[j+1]    <= nv_i_reg[j];
                dv_i_reg[j+1]    <= dv_i_reg[j];
                base_i_reg[j+1]  <= base_i_reg[j];
            end

            // alongside the projection division
            lq_d_reg[0]   <= sq_root_reg[RW];
            cr_d_reg[0]   <= cr_i_reg[RW];
            nv_d_reg[0]   <= nv_i_reg[RW];
            dv_d_reg[0]   <= dv_i_reg[RW];
            base_d_reg[0] <= base_i_reg[RW];
            deg_d_reg[0]  <= deg_i_reg[RW];
            for (int j = 1; j < LD; j++) begin
                lq_d_reg[j]   <= lq_d_reg[j-1];
                cr_d_reg[j]   <= cr_d_reg[j-1];
                nv_d_reg[j]   <= nv_d_reg[j-1];
                dv_d_reg[j]   <= dv_d_reg[j-1];
                base_d_reg[j] <= base_d_reg[j-1];
                deg_d_reg[j]  <= deg_d_reg[j-1];
            end

            for (int k = 0; k < 3; k++) begin
                am_m_reg[k]   <= AMW'(a_quo) * AMW'(nv_d_reg[LD-1][k]);
                cr_m_reg[k]   <= cr_d_reg[LD-1][k];
                dv_m_reg[k]   <= dv_d_reg[LD-1][k];
                base_m_reg[k] <= base_d_reg[LD-1][k];
            end
            lq_m_reg  <= lq_d_reg[LD-1];
            deg_m_reg <= deg_d_reg[LD-1];

            // alongside the component divisions
            dv_e_reg[0]   <= dv_m_reg;
            base_e_reg[0] <= base_m_reg;
            deg_e_reg[0]  <= deg_m_reg;
            for (int j = 1; j < LD; j++) begin
                dv_e_reg[j]   <= dv_e_reg[j-1];
                base_e_reg[j] <= base_e_reg[j-1];
                deg_e_reg[j]  <= deg_e_reg[j-1];
            end

            for (int k = 0; k < 3; k++) begin
                x_f_reg[k]  <= (XFW'(base_e_reg[LD-1][k]) <<< 1) - XFW'(dv_e_reg[LD-1][k])
                             + XFW'(p_quo[k]) + (XFW'(p_quo[k]) <<< 1);
                rp_f_reg[k] <= RPW'(r_quo[k]) * RPW'($signed({1'b0, SQRT3_Q30}));
            end
            deg_f_reg <= deg_e_reg[LD-1];
        end
    end

    ahpp_div #(.NUM_W(SW), .DEN_W(RW), .QUO_W(QW)) u_div_a (
        .aclk  (aclk),
        .en    (en),
        .num_i (t_i_reg[RW]),
        .den_i (sq_root_reg[RW]),
        .quo_o (a_quo)
    );

    for (genvar k = 0; k < 3; k++) begin : g_comp
        ahpp_div #(.NUM_W(AMW), .DEN_W(RW), .QUO_W(QW)) u_div_p (
            .aclk  (aclk),
            .en    (en),
            .num_i (am_m_reg[k]),
            .den_i (lq_m_reg),
            .quo_o (p_quo[k])
        );
        ahpp_div #(.NUM_W(SW), .DEN_W(RW), .QUO_W(QW)) u_div_r (
            .aclk  (aclk),
            .en    (en),
            .num_i (cr_m_reg[k]),
            .den_i (lq_m_reg),
            .quo_o (r_quo[k])
        );
    end

    // rounding, saturation and packing
    always_comb begin
        res_data = '0;
        for (int k = 0; k < 3; k++) begin
            sum_pos[k] = (FW'(x_f_reg[k]) <<< XS) + FW'(rp_f_reg[k]) + ROUND_HALF;
            sum_neg[k] = (FW'(x_f_reg[k]) <<< XS) - FW'(rp_f_reg[k]) + ROUND_HALF;
            if (!deg_f_reg) begin
                res_data[k*W +: W]     = sat_coord(sum_pos[k]);
                res_data[(3+k)*W +: W] = sat_coord(sum_neg[k]);
            end
        end
    end

    assign m_axis_tvalid   = out_v_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_deg_reg;

endmodule

@@ src/ahpp_checker.sv @@
// ----------------------------------------------------------------------------
// ahpp_checker
// port-level checks for amide_hydrogen_pair_placement
// ----------------------------------------------------------------------------
module ahpp_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0]                         m_axis_tuser
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    // degenerate results carry zero coordinates
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate result with non-zero coordinates");

    // input only stalls while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending output");

    // skid stage drains in one accepted output
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input still stalled after output accepted");

endmodule

bind amide_hydrogen_pair_placement ahpp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ahpp_checker (.*);

@@ dv/tb_amide_hydrogen_pair_placement.sv @@
// ----------------------------------------------------------------------------
// tb_amide_hydrogen_pair_placement
// self-checking bench for the amide hydrogen pair placement unit: directed
// extremes, degenerate geometry, saturation, random geometry and long output
// back-pressure, each result checked against an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module tb_amide_hydrogen_pair_placement;
    import ahpp_pkg::*;

    localparam int CW = 32;
    localparam int IN_W = ((9*CW+7)/8)*8;
    localparam int OUT_W = ((6*CW+7)/8)*8;
    localparam int LATENCY = 3*CW+32;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] first_x, first_y, first_z;
        logic signed [CW-1:0] second_x, second_y, second_z;
        logic                 degenerate;
    } hyd_pair_t;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    hyd_pair_t pair_q[$];
    int        n_sent, n_checked, n_mismatch, n_degenerate;
    bit        idle_on;
    int        hold_req;
    int        hold_left;

    amide_hydrogen_pair_placement #(.COORD_WIDTH(CW)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", pair_q.size());
        $display("tb_amide_hydrogen_pair_placement NOT OK");
        $finish;
    end

    function automatic logic [127:0] int_sqrt(logic [127:0] val);
        logic [127:0] res, bitv;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && bitv > val) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (val >= res + bitv) begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] round_sat(wide_t s);
        wide_t v;
        v = (s + (256'sd1 <<< 30)) >>> ROUND_SHIFT;
        if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -(256'sd1 <<< 31)) return 32'sh80000000;
        return v[CW-1:0];
    endfunction

    function automatic hyd_pair_t place_pair(logic [IN_W-1:0] item);
        wide_t base[3], nv[3], dv[3], c[3];
        wide_t q, t, lq, a, p, r, x, rk, sq3;
        logic signed [CW-1:0] fo[3], so[3];
        hyd_pair_t res;
        sq3 = $signed({1'b0, SQRT3_Q30});
        for (int k = 0; k < 3; k++) begin
            base[k] = $signed(item[CW*k +: CW]);
            nv[k] = wide_t'($signed(item[CW*(3+k) +: CW])) - base[k];
            dv[k] = wide_t'($signed(item[CW*(6+k) +: CW])) - base[k];
        end
        q = nv[0]*nv[0] + nv[1]*nv[1] + nv[2]*nv[2];
        t = dv[0]*nv[0] + dv[1]*nv[1] + dv[2]*nv[2];
        c[0] = dv[1]*nv[2] - dv[2]*nv[1];
        c[1] = dv[2]*nv[0] - dv[0]*nv[2];
        c[2] = dv[0]*nv[1] - dv[1]*nv[0];
        res = '0;
        if (q == 0 || (c[0] == 0 && c[1] == 0 && c[2] == 0)) begin
            res.degenerate = 1'b1;
            return res;
        end
        lq = $signed({128'd0, int_sqrt(q[127:0] << (2*NORM_SHIFT))});
        a = (t <<< NORM_SHIFT) / lq;
        for (int k = 0; k < 3; k++) begin
            p = ((a * nv[k]) <<< NORM_SHIFT) / lq;
            r = (c[k] <<< NORM_SHIFT) / lq;
            x = (2*base[k] - dv[k] + 3*p) <<< 30;
            rk = r * sq3;
            fo[k] = round_sat(x + rk);
            so[k] = round_sat(x - rk);
        end
        res.first_x = fo[0];  res.first_y = fo[1];  res.first_z = fo[2];
        res.second_x = so[0]; res.second_y = so[1]; res.second_z = so[2];
        return res;
    endfunction

    // nine coordinates, nitrogen first, x in the lowest bits
    function automatic logic [IN_W-1:0] pack_atoms(int nx, int ny, int nz, int cx, int cy,
                                                   int cz, int hx, int hy, int hz);
        return {hz, hy, hx, cz, cy, cx, nz, ny, nx};
    endfunction

    task automatic send_item(logic [IN_W-1:0] item);
        while (idle_on && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item;
        do @(posedge aclk); while (!s_axis_tready);
        pair_q.insert(pair_q.size(), place_pair(item));
        n_sent++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req > 0) begin
            hold_left <= hold_req;
            hold_req = 0;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 6);
        end
    end

    always @(posedge aclk) begin
        hyd_pair_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[6*CW-1:0], m_axis_tuser[0]};
            got = '{first_x: m_axis_tdata[0 +: CW], first_y: m_axis_tdata[CW +: CW],
                    first_z: m_axis_tdata[2*CW +: CW], second_x: m_axis_tdata[3*CW +: CW],
                    second_y: m_axis_tdata[4*CW +: CW], second_z: m_axis_tdata[5*CW +: CW],
                    degenerate: m_axis_tuser[0]};
            if (pair_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result transaction %p", got);
            end else begin
                want = pair_q.pop_front();
                n_checked++;
                if (want.degenerate) n_degenerate++;
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("mismatch on result %0d", n_checked);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    function automatic int near_coord(int centre);
        return centre + $signed($urandom_range(0, 2*(3 << 16))) - (3 << 16);
    endfunction

    function automatic logic [IN_W-1:0] random_geometry();
        int nx, ny, nz;
        logic [IN_W-1:0] item;
        case ($urandom_range(9))
            0, 1: begin
                for (int k = 0; k < 9; k++) item[CW*k +: CW] = $urandom;
            end
            2: begin
                nx = $urandom; ny = $urandom; nz = $urandom;
                item = pack_atoms(nx, ny, nz, near_coord(nx), near_coord(ny), near_coord(nz),
                                  near_coord(nx), near_coord(ny), near_coord(nz));
            end
            default: begin
                nx = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
                ny = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
                nz = $signed($urandom_range(0, 400 << 16)) - (200 << 16);
                item = pack_atoms(nx, ny, nz, near_coord(nx), near_coord(ny), near_coord(nz),
                                  near_coord(nx), near_coord(ny), near_coord(nz));
            end
        endcase
        return item;
    endfunction

    task automatic test_typical_geometry();
        send_item(pack_atoms(0, 0, 0, 32'sd86508, 0, 0, -32'sd32768, 32'sd56756, 0));
        send_item(pack_atoms(32'sd655360, -32'sd327680, 32'sd131072, 32'sd720000,
                             -32'sd300000, 32'sd190000, 32'sd600000, -32'sd280000,
                             32'sd150000));
        send_item(pack_atoms(1, 2, 3, 2, 2, 3, 1, 3, 3));
        send_item(pack_atoms(0, 0, 0, 0, 0, 1, 1, 0, 0));
    endtask

    task automatic test_degenerate();
        send_item(pack_atoms(5, 6, 7, 5, 6, 7, 100, 200, 300));
        send_item(pack_atoms(5, 6, 7, 50, 60, 70, 5, 6, 7));
        send_item(pack_atoms(5, 6, 7, 50, 60, 70, 95, 114, 133));
        send_item(pack_atoms(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_atoms(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_extremes();
        int mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        send_item(pack_atoms(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_item(pack_atoms(mn, mn, mn, mx, mx, mx, mn, mx, mn));
        send_item(pack_atoms(mx, mn, 0, mn, mx, 0, 0, 0, mx));
        send_item(pack_atoms(mn, mx, mn, mn, mx, mx, mx, mx, mn));
        send_item(pack_atoms(mx, mx, mx, mx - 1, mx, mx, mx, mx - 1, mx));
        send_item(pack_atoms(mn, mn, mn, mn + 1, mn, mn, mn, mn + 1, mn));
        send_item(pack_atoms(0, 0, 0, 1, 0, 0, mn, mx, mx));
        send_item(pack_atoms(mx, 0, mn, mx, 1, mn, mx - 7, 0, mn + 3));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i == 150) idle_on = 1'b0;
            if (i == 300) idle_on = 1'b1;
            send_item(random_geometry());
        end
    endtask

    task automatic test_output_stall();
        hold_req = 400;
        for (int i = 0; i < 80; i++) send_item(random_geometry());
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        idle_on = 1'b1;
        hold_req = 0;
        hold_left = 0;
        n_sent = 0;
        n_checked = 0;
        n_mismatch = 0;
        n_degenerate = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_typical_geometry();
        test_degenerate();
        test_extremes();
        test_random(600);
        test_output_stall();
        test_random(50);
        s_axis_tvalid <= 1'b0;
        while (pair_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("%0d placements sent, %0d checked (%0d degenerate), %0d mismatches",
                 n_sent, n_checked, n_degenerate, n_mismatch);
        $display("covered extremes, saturation, degenerate geometry, idling and a long stall");
        if (n_mismatch == 0 && pair_q.size() == 0)
            $display("tb_amide_hydrogen_pair_placement OK");
        else
            $display("tb_amide_hydrogen_pair_placement NOT OK");
        $finish;
    end
endmodule

@@ amide_hydrogen_pair_placement.f @@
src/ahpp_pkg.sv
src/ahpp_div.sv
src/amide_hydrogen_pair_placement.sv
src/ahpp_checker.sv
dv/tb_amide_hydrogen_pair_placement.sv
